// ===== design/rgbc_pkg.sv =====
// Shared types and constants of the RGB 3x3 convolution block.
`default_nettype none

package rgbc_pkg;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// Kernel codes; the unused code behaves as emboss
	localparam logic [1:0] KERN_EMBOSS  = 2'd0;
	localparam logic [1:0] KERN_BLUR    = 2'd1;
	localparam logic [1:0] KERN_SHARPEN = 2'd2;

	// Input word op codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Reset values of the frame size registers
	localparam int FRAME_W_RST = 1024;
	localparam int FRAME_H_RST = 1024;

	// Kernel taps, row-major from top-left; blur holds 0.11 as 28/256
	localparam logic signed [5:0] KERN_TAPS [3][9] = '{
		'{-6'sd2, -6'sd1,  6'sd0, -6'sd1,  6'sd1,  6'sd1,  6'sd0,  6'sd1,  6'sd2},
		'{ 6'sd28, 6'sd28, 6'sd28, 6'sd28, 6'sd28, 6'sd28, 6'sd28, 6'sd28, 6'sd28},
		'{-6'sd1,  6'sd0, -6'sd1,  6'sd0,  6'sd4,  6'sd0, -6'sd1,  6'sd0, -6'sd1}
	};
	localparam int KERN_SHIFT [3] = '{0, 8, 0};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_done;
	} out_word_t;

endpackage

`default_nettype wire

// ===== design/rgb_conv3x3_clamp_unit.sv =====
// Top level of the streaming RGB 3x3 convolution with clamping.
`default_nettype none

// Streaming 3x3 filter over raster-order RGB pixels. One word is taken per
// clock whenever the result register is free or being drained, and results
// leave via stage 1, the window and the result register after the word that
// completes their window. Two line memories of MAX_WIDTH pixels (one read and
// one write port each) delay the stream by one and two rows; a 3x3 register
// window slides across them, and the edge taps are masked from the output
// position. Result o appears for the input word that carries pixel o+width+1;
// after the last pixel of a frame, width+1 further words (flush or pixel, data
// ignored) drain the tail, and flush words that arrive during a frame are
// dropped. A single-row frame pushes one of those as padding after its last
// pixel, taking no word while it does so. Writing frame_width or frame_height
// restarts the frame. The line memories need no clearing after reset.
module rgb_conv3x3_clamp_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pix_valid,
	output      logic                                pix_ready,
	input  wire rgbc_pkg::in_word_t                  pix,
	output      logic                                res_valid,
	input  wire logic                                res_ready,
	output      rgbc_pkg::out_word_t                 res,
	input  wire logic                                cfg_we,
	input  wire logic [rgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST = (rgbc_pkg::FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH
		: rgbc_pkg::FRAME_W_RST;
	localparam int H_RST = (rgbc_pkg::FRAME_H_RST > MAX_HEIGHT) ? MAX_HEIGHT
		: rgbc_pkg::FRAME_H_RST;

	typedef struct packed {
		logic emit;
		logic done;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} ctl_t;

	// Filter one channel of a masked 3x3 neighborhood and clamp to 0..255
	function automatic logic [7:0] filt(input logic [1:0] ks, input logic [8:0][7:0] t);
		logic signed [17:0] v [9];
		logic signed [17:0] se;
		logic signed [17:0] sb;
		logic signed [17:0] ss;
		logic signed [17:0] sel;
		logic [7:0]         r;
		se = '0;
		sb = '0;
		ss = '0;
		for (int i = 0; i < 9; i++) begin
			v[i] = $signed({10'd0, t[i]});
			se = se + 18'(rgbc_pkg::KERN_TAPS[0][i]) * v[i];
			sb = sb + 18'(rgbc_pkg::KERN_TAPS[1][i]) * v[i];
			ss = ss + 18'(rgbc_pkg::KERN_TAPS[2][i]) * v[i];
		end
		case (ks)
			rgbc_pkg::KERN_BLUR:    sel = sb >>> rgbc_pkg::KERN_SHIFT[1];
			rgbc_pkg::KERN_SHARPEN: sel = ss >>> rgbc_pkg::KERN_SHIFT[2];
			default:                sel = se >>> rgbc_pkg::KERN_SHIFT[0];
		endcase
		if (sel < 0) begin
			r = 8'd0;
		end else if (sel > 18'sd255) begin
			r = 8'd255;
		end else begin
			r = sel[7:0];
		end
		return r;
	endfunction

	// Configuration and position state
	logic [1:0]    kern_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] kc_q;
	logic [RW-1:0] kr_q;
	logic          phantom_q;

	// Front-end decode
	logic          adv;
	logic          acc_in;
	logic          in_frame;
	logic          push_0;
	logic          col_last;
	logic          set_phantom;
	rgbc_pkg::rgb_t pix_0;
	logic [RW-1:0] orow_0;
	logic [CW-1:0] oc_0;
	ctl_t          ctl_0;

	// Stage 1: pushed pixel and line memory reads
	logic           v_s1;
	ctl_t           ctl_s1;
	rgbc_pkg::rgb_t pix_s1;
	logic [CW-1:0]  kc_s1;
	rgbc_pkg::rgb_t rda_s1;
	rgbc_pkg::rgb_t rdb_s1;
	logic           byp_s1;
	rgbc_pkg::rgb_t bypa_s1;
	rgbc_pkg::rgb_t bypb_s1;
	rgbc_pkg::rgb_t rd_a;
	rgbc_pkg::rgb_t rd_b;

	rgbc_pkg::rgb_t mem_a [MAX_WIDTH];
	rgbc_pkg::rgb_t mem_b [MAX_WIDTH];

	// Stage 2: window
	rgbc_pkg::rgb_t win_s2 [3][3];
	ctl_t           ctl_s2;
	logic           ev_s2;

	logic [2:0]      row_ok;
	logic [2:0]      col_ok;
	logic [8:0][7:0] tap_r;
	logic [8:0][7:0] tap_g;
	logic [8:0][7:0] tap_b;
	rgbc_pkg::out_word_t res_d;

	// Advance the whole pipeline when the result register is free or drained
	assign adv       = !res_valid || res_ready;
	assign pix_ready = adv && !phantom_q;
	assign acc_in    = pix_valid && pix_ready;
	assign in_frame  = kr_q < RW'(h_q);
	assign push_0    = (phantom_q && adv) || (acc_in && (!in_frame || pix.op == rgbc_pkg::OP_PIXEL));
	assign col_last  = (WW'(kc_q) + WW'(1)) == w_q;
	assign set_phantom = acc_in && in_frame && pix.op == rgbc_pkg::OP_PIXEL
		&& h_q == HW'(1) && col_last;

	// Select pushed pixel; flush and padding words push black
	always_comb begin
		if (in_frame) begin
			pix_0 = '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in};
		end else begin
			pix_0 = '0;
		end
	end

	// Locate the output centered one row up and one column left of the push
	always_comb begin
		if (kc_q == '0) begin
			oc_0   = CW'(w_q - WW'(1));
			orow_0 = kr_q - RW'(2);
		end else begin
			oc_0   = kc_q - CW'(1);
			orow_0 = kr_q - RW'(1);
		end
		ctl_0.emit     = (kr_q >= RW'(2)) || (kr_q == RW'(1) && kc_q != '0);
		ctl_0.done     = ctl_0.emit && orow_0 == (RW'(h_q) - RW'(1))
			&& WW'(oc_0) == (w_q - WW'(1));
		ctl_0.top_ok   = orow_0 != '0;
		ctl_0.bot_ok   = orow_0 != (RW'(h_q) - RW'(1));
		ctl_0.left_ok  = oc_0 != '0;
		ctl_0.right_ok = WW'(oc_0) != (w_q - WW'(1));
	end

	// Configuration writes and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q    <= rgbc_pkg::KERN_EMBOSS;
			w_q       <= WW'(W_RST);
			h_q       <= HW'(H_RST);
			kc_q      <= '0;
			kr_q      <= '0;
			phantom_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbc_pkg::CFG_KERNEL: begin
					kern_q <= cfg_data[1:0];
				end
				rgbc_pkg::CFG_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WW'(1);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
					kc_q      <= '0;
					kr_q      <= '0;
					phantom_q <= 1'b0;
				end
				rgbc_pkg::CFG_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= HW'(1);
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
					kc_q      <= '0;
					kr_q      <= '0;
					phantom_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (push_0) begin
			phantom_q <= set_phantom;
			if (ctl_0.done) begin
				kc_q <= '0;
				kr_q <= '0;
			end else if (col_last) begin
				kc_q <= '0;
				kr_q <= kr_q + RW'(1);
			end else begin
				kc_q <= kc_q + CW'(1);
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			v_s1   <= push_0;
			ctl_s1 <= ctl_0;
		end
	end

	// Stage 1 payload and write-to-read forwarding for one-pixel rows
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pix_0;
			kc_s1   <= kc_q;
			byp_s1  <= v_s1 && kc_q == kc_s1;
			bypa_s1 <= pix_s1;
			bypb_s1 <= rd_a;
		end
	end

	assign rd_a = byp_s1 ? bypa_s1 : rda_s1;
	assign rd_b = byp_s1 ? bypb_s1 : rdb_s1;

	// Line memories: read at the push column, write back as the word advances
	always_ff @(posedge clk) begin
		if (adv) begin
			rda_s1 <= mem_a[kc_q];
			rdb_s1 <= mem_b[kc_q];
		end
		if (adv && v_s1) begin
			mem_a[kc_s1] <= pix_s1;
			mem_b[kc_s1] <= rd_a;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s2  <= 1'b0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ev_s2  <= v_s1 && ctl_s1.emit;
			ctl_s2 <= ctl_s1;
		end
	end

	// Shift a new column into the window on every push
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_s2[r][0] <= win_s2[r][1];
				win_s2[r][1] <= win_s2[r][2];
			end
			win_s2[0][2] <= rd_b;
			win_s2[1][2] <= rd_a;
			win_s2[2][2] <= pix_s1;
		end
	end

	// Mask taps outside the frame and filter each channel
	always_comb begin
		row_ok = {ctl_s2.bot_ok, 1'b1, ctl_s2.top_ok};
		col_ok = {ctl_s2.right_ok, 1'b1, ctl_s2.left_ok};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tap_r[r*3+c] = (row_ok[r] && col_ok[c]) ? win_s2[r][c].red   : 8'd0;
				tap_g[r*3+c] = (row_ok[r] && col_ok[c]) ? win_s2[r][c].green : 8'd0;
				tap_b[r*3+c] = (row_ok[r] && col_ok[c]) ? win_s2[r][c].blue  : 8'd0;
			end
		end
		res_d.red_out    = filt(kern_q, tap_r);
		res_d.green_out  = filt(kern_q, tap_g);
		res_d.blue_out   = filt(kern_q, tap_b);
		res_d.frame_done = ctl_s2.done;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= ev_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/rgbc_check.sv =====
// Port-level checks of the RGB 3x3 convolution block and their binding.
`default_nettype none

module rgbc_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                pix_valid,
	input wire logic                pix_ready,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire rgbc_pkg::out_word_t res
);

	// Hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// Drop ready only for a stalled result or the padding push after a word
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (res_valid && !res_ready) || $past(pix_valid && pix_ready))
		else $error("input stalled without cause");

	// A free-running result comes from a word via stage 1 and the window
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) && !$past(res_valid, 2) && !$past(res_valid, 3)
		|-> $past(pix_valid && pix_ready, 3))
		else $error("result word without a source word");

endmodule

bind rgb_conv3x3_clamp_unit rgbc_check u_rgbc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire

// ===== dv/tb_rgb_conv3x3_clamp_unit.sv =====
// Self-checking testbench for the streaming RGB 3x3 convolution and clamp unit.
module tb_rgb_conv3x3_clamp_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbc_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 1024;
	localparam int RAND_WORDS  = 600;
	localparam int SETTLE      = 8;
	localparam int HOLD_LEN    = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTS  = 50;

	// Tap weights, row-major from the top-left neighbor
	localparam int EMBOSS_TAP  [9] = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
	localparam int SHARPEN_TAP [9] = '{-1, 0, -1, 0, 4, 0, -1, 0, -1};
	localparam int BLUR_TAP        = 28;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	in_word_t              pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	out_word_t             res;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_KERNEL;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Filter shadow: three rotating line stores, positions and registers
	rgb_t        row_store [3][MAX_W];
	int          col_pos    = 0;
	int          row_pos    = 0;
	int          out_pos    = 0;
	logic [1:0]  kern_sel   = KERN_EMBOSS;
	logic [10:0] width_reg  = 11'(FRAME_W_RST);
	logic [10:0] height_reg = 11'(FRAME_H_RST);

	in_word_t  pend_q [$];
	out_word_t filtered_q [$];

	int err_cnt   = 0;
	int word_cnt  = 0;
	int snd_wait  = 0;
	int rcv_wait  = 0;
	int hold_left = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int quiet_cyc = 0;
	bit snd_burst = 1'b0;
	bit rcv_burst = 1'b0;

	rgb_conv3x3_clamp_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clip_dim(logic [10:0] v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic void rewind_frame();
		col_pos = 0;
		row_pos = 0;
		out_pos = 0;
	endfunction

	function automatic int tap_of(int idx);
		case (kern_sel)
			KERN_BLUR:    return BLUR_TAP;
			KERN_SHARPEN: return SHARPEN_TAP[idx];
			default:      return EMBOSS_TAP[idx];
		endcase
	endfunction

	// Floor the blur sum by the Q0.8 scale, then clamp to a byte
	function automatic logic [7:0] clamp_chan(int acc);
		int v;
		if (acc < 0)
			return 8'd0;
		v = (kern_sel == KERN_BLUR) ? (acc >>> 8) : acc;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Compute output pixel out_pos; the pixel arriving now may be one of its taps
	function automatic out_word_t filter_at(bit has_new, int nr, int nc, rgb_t npix);
		int        w, h, total, r, c, rr, cc, wt;
		int        acc [3];
		rgb_t      p;
		out_word_t o;
		w     = clip_dim(width_reg, MAX_W);
		h     = clip_dim(height_reg, MAX_H);
		total = w * h;
		r     = out_pos / w;
		c     = out_pos % w;
		acc   = '{0, 0, 0};
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				rr = r + dr;
				cc = c + dc;
				if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
					wt = tap_of((dr + 1) * 3 + dc + 1);
					p  = (has_new && rr == nr && cc == nc) ? npix : row_store[rr % 3][cc];
					acc[0] += wt * int'(p.red);
					acc[1] += wt * int'(p.green);
					acc[2] += wt * int'(p.blue);
				end
			end
		end
		o.red_out    = clamp_chan(acc[0]);
		o.green_out  = clamp_chan(acc[1]);
		o.blue_out   = clamp_chan(acc[2]);
		o.frame_done = (out_pos + 1 >= total);
		out_pos++;
		if (out_pos >= total)
			rewind_frame();
		return o;
	endfunction

	// Advance the shadow by one accepted word and queue any filtered pixel it yields
	function automatic void filter_word(in_word_t wd);
		int   w, h, r, c;
		rgb_t px;
		w  = clip_dim(width_reg, MAX_W);
		h  = clip_dim(height_reg, MAX_H);
		px = {wd.red_in, wd.green_in, wd.blue_in};
		if (wd.op == OP_PIXEL && row_pos < h) begin
			r = row_pos;
			c = col_pos;
			if (r * w + c >= w + 1)
				filtered_q.push_back(filter_at(1'b1, r, c, px));
			row_store[r % 3][c] = px;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col_pos = c;
			row_pos = r;
		end else if (row_pos >= h && out_pos < w * h) begin
			filtered_q.push_back(filter_at(1'b0, 0, 0, '0));
		end
	endfunction

	task automatic report_mismatch(string what, int got_v, int want_v);
		if (err_cnt < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
		err_cnt++;
	endtask

	// Drive: hold each word until taken, then wait the drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			snd_wait  <= 0;
		end else begin
			if (pix_valid && pix_ready) begin
				filter_word(pix);
				if ($urandom_range(0, 39) == 0)
					snd_burst <= !snd_burst;
			end
			if (!pix_valid || pix_ready) begin
				if (snd_wait > 0) begin
					snd_wait  <= snd_wait - 1;
					pix_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					pix       <= pend_q.pop_front();
					pix_valid <= 1'b1;
					snd_wait  <= snd_burst ? 0 : $urandom_range(0, 6);
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result, then stall or hold off as asked
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		int        stall;
		if (!arst_n) begin
			res_ready <= 1'b0;
			rcv_wait  <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (filtered_q.size() == 0) begin
					report_mismatch("result with none expected", res, 0);
				end else begin
					want = filtered_q.pop_front();
					if (res.red_out != want.red_out)
						report_mismatch("red_out", res.red_out, want.red_out);
					if (res.green_out != want.green_out)
						report_mismatch("green_out", res.green_out, want.green_out);
					if (res.blue_out != want.blue_out)
						report_mismatch("blue_out", res.blue_out, want.blue_out);
					if (res.frame_done != want.frame_done)
						report_mismatch("frame_done", res.frame_done, want.frame_done);
				end
			end
			if (hold_seen != hold_asks) begin
				hold_seen <= hold_asks;
				hold_left <= HOLD_LEN;
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ready <= 1'b0;
			end else if (res_valid && res_ready) begin
				stall = rcv_burst ? 0 : $urandom_range(0, 6);
				rcv_wait  <= stall;
				res_ready <= (stall == 0);
				if ($urandom_range(0, 39) == 0)
					rcv_burst <= !rcv_burst;
			end else if (rcv_wait > 0) begin
				rcv_wait  <= rcv_wait - 1;
				res_ready <= (rcv_wait == 1);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= STALL_LIMIT) begin
			$display("tb_rgb_conv3x3_clamp_unit: done, errors");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	function automatic logic [7:0] chan_val();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Queue n pixels, with stray flush words mixed in when noisy that the block must drop
	task automatic queue_pixels(int n, bit noisy);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				pend_q.push_back(in_word_t'({OP_FLUSH, chan_val(), chan_val(), chan_val()}));
			pend_q.push_back(in_word_t'({OP_PIXEL, chan_val(), chan_val(), chan_val()}));
			word_cnt++;
		end
	endtask

	// Queue the tail drain: mostly flush words, some pixels whose data is dropped
	task automatic queue_drain(int n);
		logic op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH;
			pend_q.push_back(in_word_t'({op, chan_val(), chan_val(), chan_val()}));
			word_cnt++;
		end
	endtask

	// Wait until every word is taken and every result is in, then let the pipe settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || pix_valid || filtered_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one register; the caller drops the write enable after the last one
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_KERNEL: kern_sel = val[1:0];
			CFG_WIDTH: begin
				width_reg = val;
				rewind_frame();
			end
			CFG_HEIGHT: begin
				height_reg = val;
				rewind_frame();
			end
			default: ;
		endcase
	endtask

	task automatic setup_frame(logic [1:0] kern, logic [10:0] fw, logic [10:0] fh);
		wait_idle();
		cfg_write(CFG_KERNEL, 11'(kern));
		cfg_write(CFG_WIDTH, fw);
		cfg_write(CFG_HEIGHT, fh);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [1:0]  kern;
		logic [10:0] fw, fh;
		int          w, h, n;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Emboss 3x3 with extreme pixels, a stray flush mid-frame and a pixel in the drain
		setup_frame(KERN_EMBOSS, 11'd3, 11'd3);
		for (int i = 0; i < 9; i++) begin
			pend_q.push_back(in_word_t'({OP_PIXEL,
				(i == 4) ? 24'hFF00FF : ((i % 2) ? 24'h000000 : 24'hFFFFFF)}));
			if (i == 2)
				pend_q.push_back(in_word_t'({OP_FLUSH, 24'hFFFFFF}));
		end
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'h5A3CC3}));
		queue_drain(3);

		// Unused kernel code with zero sizes: a single-pixel frame
		setup_frame(2'd3, 11'd0, 11'd0);
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'hFFFFFF}));
		queue_drain(2);

		// Blur of a saturated single row
		setup_frame(KERN_BLUR, 11'd2, 11'd1);
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'hFFFFFF}));
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'hFFFFFF}));
		queue_drain(3);

		// Sharpen of a single row: bright channels clamp high, dark ones stay zero
		setup_frame(KERN_SHARPEN, 11'd2, 11'd1);
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'hFF00FF}));
		pend_q.push_back(in_word_t'({OP_PIXEL, 24'h00FF00}));
		queue_drain(3);

		// Size extremes, including values that saturate to the maximum
		setup_frame(KERN_SHARPEN, 11'd1024, 11'd1);
		queue_pixels(1024, 1'b1);
		queue_drain(1025);
		setup_frame(KERN_BLUR, 11'd1, 11'd1024);
		queue_pixels(1024, 1'b1);
		queue_drain(2);
		setup_frame(KERN_EMBOSS, 11'h7FF, 11'd2);
		queue_pixels(2048, 1'b0);
		queue_drain(1025);
		setup_frame(2'd3, 11'd2, 11'h7FF);
		queue_pixels(2048, 1'b0);
		queue_drain(3);

		// Back-pressure: hold results off while the sender keeps offering words
		setup_frame(KERN_SHARPEN, 11'd16, 11'd10);
		hold_asks++;
		queue_pixels(160, 1'b0);
		queue_drain(17);

		// Random frames: mostly complete, some abandoned, some with a kernel switch
		word_cnt = 0;
		while (word_cnt < RAND_WORDS) begin
			kern = 2'($urandom_range(0, 3));
			fw   = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 40))
			                                   : 11'($urandom_range(1, 8));
			fh   = 11'($urandom_range(0, 6));
			setup_frame(kern, fw, fh);
			w = clip_dim(fw, MAX_W);
			h = clip_dim(fh, MAX_H);
			case ($urandom_range(0, 9))
				0: queue_pixels($urandom_range(0, w * h - 1), 1'b1);
				1: begin
					n = $urandom_range(0, w * h);
					queue_pixels(n, 1'b1);
					wait_idle();
					cfg_write(CFG_KERNEL, 11'($urandom_range(0, 3)));
					cfg_we <= 1'b0;
					queue_pixels(w * h - n, 1'b1);
					queue_drain(w + 1);
				end
				default: begin
					queue_pixels(w * h, 1'b1);
					queue_drain(w + 1);
					// Flush after the frame has ended: dropped
					if ($urandom_range(0, 4) == 0)
						pend_q.push_back(in_word_t'({OP_FLUSH, 24'h0F0F0F}));
				end
			endcase
		end

		wait_idle();
		if (err_cnt == 0)
			$display("tb_rgb_conv3x3_clamp_unit: done, clean");
		else
			$display("tb_rgb_conv3x3_clamp_unit: done, errors");
		$finish;
	end

endmodule
